// File: sv/cml_pkg.sv
package cml_pkg;

   // Field widths of the result channel.
   localparam int KindWidth = 4;
   localparam int CharWidth = 8;
   localparam int LineWidth = 16;

   // Default width of the row and column counters.
   localparam int PosBitsDefault = 16;

   // Token kind codes.
   typedef enum logic [KindWidth-1:0] {
      KIND_LIT      = 4'd0,
      KIND_END      = 4'd1,
      KIND_EQUALS   = 4'd2,
      KIND_COMMA    = 4'd3,
      KIND_SEMI     = 4'd4,
      KIND_LBRACKET = 4'd5,
      KIND_RBRACKET = 4'd6,
      KIND_LBRACE   = 4'd7,
      KIND_RBRACE   = 4'd8,
      KIND_EOF      = 4'd9,
      KIND_EOF_STR  = 4'd10,
      KIND_EOF_CMT  = 4'd11
   } kind_type;

   // Character codes the lexer reacts to.
   localparam logic [CharWidth-1:0] CharEnd       = 8'h00;
   localparam logic [CharWidth-1:0] CharTab       = 8'h09;
   localparam logic [CharWidth-1:0] CharNewline   = 8'h0A;
   localparam logic [CharWidth-1:0] CharCr        = 8'h0D;
   localparam logic [CharWidth-1:0] CharSpace     = 8'h20;
   localparam logic [CharWidth-1:0] CharQuote     = 8'h22;
   localparam logic [CharWidth-1:0] CharStar      = 8'h2A;
   localparam logic [CharWidth-1:0] CharComma     = 8'h2C;
   localparam logic [CharWidth-1:0] CharSlash     = 8'h2F;
   localparam logic [CharWidth-1:0] CharSemi      = 8'h3B;
   localparam logic [CharWidth-1:0] CharEquals    = 8'h3D;
   localparam logic [CharWidth-1:0] CharLBracket  = 8'h5B;
   localparam logic [CharWidth-1:0] CharBackslash = 8'h5C;
   localparam logic [CharWidth-1:0] CharRBracket  = 8'h5D;
   localparam logic [CharWidth-1:0] CharLBrace    = 8'h7B;
   localparam logic [CharWidth-1:0] CharRBrace    = 8'h7D;

   // Space, tab, newline, vertical tab, form feed and carriage return.
   function automatic logic is_space(input logic [CharWidth-1:0] c);
      return c inside {CharSpace, [CharTab:CharCr]};
   endfunction

   // Kind of a punctuation byte; the literal code when it is not punctuation.
   function automatic kind_type punct_kind(input logic [CharWidth-1:0] c);
      kind_type k;
      case (c)
         CharEquals:   k = KIND_EQUALS;
         CharComma:    k = KIND_COMMA;
         CharSemi:     k = KIND_SEMI;
         CharLBracket: k = KIND_LBRACKET;
         CharRBracket: k = KIND_RBRACKET;
         CharLBrace:   k = KIND_LBRACE;
         CharRBrace:   k = KIND_RBRACE;
         default:      k = KIND_LIT;
      endcase
      return k;
   endfunction

   // Bytes that close a bare literal.
   function automatic logic ends_bare(input logic [CharWidth-1:0] c);
      return is_space(c) ||
             (c inside {CharEquals, CharComma, CharSemi, CharRBracket, CharRBrace});
   endfunction

endpackage

// File: sv/config_map_lexer_top.sv
// Character-serial lexer for a configuration-map text format.
// Input channel (req_): one byte per beat on req_char_in; a zero byte ends the
// stream. Result channel (rsp_): token beats with kind, content byte, row,
// column, and rsp_last_result marking the final beat caused by one input byte.
// An input byte yields zero to three result beats. All of its beats carry the
// row and column of that byte.
// The first result beat of a byte is offered in the cycle after the byte is
// accepted. Throughput: one input byte per cycle while rsp_stall is low and
// each byte yields at most one result; a byte with several results holds req_stall
// until its last beat leaves, since the buffer sends at most one beat per cycle.
// A new byte is taken in the same cycle the last pending beat is taken.
// When the receiver asserts rsp_stall, the pending beat holds steady and
// req_stall rises as soon as a byte's results are buffered.
// Reset (synchronous) returns the lexer to idle between tokens, row and column
// to 1, and empties the result buffer. A zero byte does the same after giving
// its end-of-input results, so a new stream can follow at once.
module config_map_lexer_top #(
   parameter int POSITION_BITS = cml_pkg::PosBitsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cml_pkg::CharWidth-1:0]    req_char_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cml_pkg::KindWidth-1:0]    rsp_token_kind,
   output logic [cml_pkg::CharWidth-1:0]    rsp_char_out,
   output logic [cml_pkg::LineWidth-1:0]    rsp_line_number,
   output logic [cml_pkg::LineWidth-1:0]    rsp_column_number,
   output logic                             rsp_last_result
);
   import cml_pkg::*;

   localparam int Slots = 3;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_BARE,
      MODE_QUOTED,
      MODE_ESCAPE,
      MODE_SLASH,
      MODE_BLOCK,
      MODE_LINE
   } mode_type;

   localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] PosMax = '1;

   mode_type                 mode_ff, mode_in;
   logic                     star_ff, star_in;
   logic [POSITION_BITS-1:0] row_ff, row_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;

   kind_type                 kind_ff [Slots];
   kind_type                 kind_in [Slots];
   logic [CharWidth-1:0]     char_ff [Slots];
   logic [CharWidth-1:0]     char_in [Slots];
   logic [LineWidth-1:0]     line_ff;
   logic [LineWidth-1:0]     column_ff;
   logic [1:0]               cnt_ff, cnt_in;
   logic [1:0]               idx_ff;

   logic                     req_fire;
   logic                     rsp_fire;
   logic                     last_beat;

   logic [2:0]               tab_off;
   logic [3:0]               tab_step;
   logic [POSITION_BITS:0]   tab_sum;

   // Handshakes: the buffer reloads in the cycle its last beat is taken.
   assign last_beat = (idx_ff == (cnt_ff - 2'd1));
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign req_stall = rsp_valid && !(rsp_fire && last_beat);
   assign req_fire  = req_valid && !req_stall;

   // Pending result beat.
   assign rsp_token_kind    = kind_ff[idx_ff];
   assign rsp_char_out      = char_ff[idx_ff];
   assign rsp_line_number   = line_ff;
   assign rsp_column_number = column_ff;
   assign rsp_last_result   = last_beat;

   // Next tab stop at 1 + 8k.
   assign tab_off  = col_ff[2:0] - 3'd1;
   assign tab_step = 4'd8 - {1'b0, tab_off};
   assign tab_sum  = {1'b0, col_ff} + (POSITION_BITS + 1)'(tab_step);

   // Lexer step for the byte on the input port.
   always_comb begin
      logic [1:0] n;
      logic       do_idle;
      kind_type   pk;

      n       = 2'd0;
      do_idle = 1'b0;
      pk      = punct_kind(req_char_in);
      mode_in = mode_ff;
      star_in = star_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      for (int i = 0; i < Slots; i++) begin
         kind_in[i] = KIND_LIT;
         char_in[i] = '0;
      end

      if (req_char_in == CharEnd) begin
         // End of input: close whatever is open, then start a fresh stream.
         case (mode_ff)
            MODE_BARE: begin
               kind_in[0] = KIND_END;
               kind_in[1] = KIND_EOF;
               n = 2'd2;
            end
            MODE_QUOTED, MODE_ESCAPE: begin
               kind_in[0] = KIND_EOF_STR;
               n = 2'd1;
            end
            MODE_SLASH: begin
               kind_in[0] = KIND_LIT;
               char_in[0] = CharSlash;
               kind_in[1] = KIND_END;
               kind_in[2] = KIND_EOF;
               n = 2'd3;
            end
            MODE_BLOCK: begin
               kind_in[0] = KIND_EOF_CMT;
               n = 2'd1;
            end
            default: begin
               kind_in[0] = KIND_EOF;
               n = 2'd1;
            end
         endcase
         mode_in = MODE_IDLE;
         star_in = 1'b0;
         row_in  = PosOne;
         col_in  = PosOne;
      end else begin
         case (mode_ff)
            MODE_BARE: begin
               kind_in[0] = ends_bare(req_char_in) ? KIND_END : KIND_LIT;
               char_in[0] = ends_bare(req_char_in) ? '0 : req_char_in;
               n = 2'd1;
               do_idle = ends_bare(req_char_in);
            end
            MODE_QUOTED: begin
               kind_in[0] = KIND_LIT;
               char_in[0] = req_char_in;
               n = 2'd1;
               if (req_char_in == CharQuote) begin
                  kind_in[1] = KIND_END;
                  n = 2'd2;
                  mode_in = MODE_IDLE;
               end else if (req_char_in == CharBackslash) begin
                  mode_in = MODE_ESCAPE;
               end
            end
            MODE_ESCAPE: begin
               kind_in[0] = KIND_LIT;
               char_in[0] = req_char_in;
               n = 2'd1;
               mode_in = MODE_QUOTED;
            end
            MODE_SLASH: begin
               if (req_char_in == CharStar) begin
                  mode_in = MODE_BLOCK;
                  star_in = 1'b0;
               end else if (req_char_in == CharSlash) begin
                  mode_in = MODE_LINE;
               end else if (ends_bare(req_char_in)) begin
                  // The lone slash was a one-byte literal.
                  kind_in[0] = KIND_LIT;
                  char_in[0] = CharSlash;
                  kind_in[1] = KIND_END;
                  n = 2'd2;
                  do_idle = 1'b1;
               end else begin
                  kind_in[0] = KIND_LIT;
                  char_in[0] = CharSlash;
                  kind_in[1] = KIND_LIT;
                  char_in[1] = req_char_in;
                  n = 2'd2;
                  mode_in = MODE_BARE;
               end
            end
            MODE_BLOCK: begin
               if (req_char_in == CharSlash && star_ff) begin
                  mode_in = MODE_IDLE;
                  star_in = 1'b0;
               end else begin
                  star_in = (req_char_in == CharStar);
               end
            end
            MODE_LINE: begin
               if (req_char_in == CharNewline) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         // Start of a token from idle.
         if (do_idle) begin
            mode_in = MODE_IDLE;
            if (is_space(req_char_in)) begin
               mode_in = MODE_IDLE;
            end else if (pk != KIND_LIT) begin
               kind_in[n] = pk;
               n = n + 2'd1;
            end else if (req_char_in == CharQuote) begin
               kind_in[n] = KIND_LIT;
               char_in[n] = req_char_in;
               n = n + 2'd1;
               mode_in = MODE_QUOTED;
            end else if (req_char_in == CharSlash) begin
               mode_in = MODE_SLASH;
            end else begin
               kind_in[n] = KIND_LIT;
               char_in[n] = req_char_in;
               n = n + 2'd1;
               mode_in = MODE_BARE;
            end
         end

         // Position of the next byte, saturating.
         if (req_char_in == CharNewline) begin
            row_in = (row_ff == PosMax) ? PosMax : row_ff + PosOne;
            col_in = PosOne;
         end else if (req_char_in == CharTab) begin
            col_in = tab_sum[POSITION_BITS] ? PosMax : tab_sum[POSITION_BITS-1:0];
         end else if (req_char_in != CharCr) begin
            col_in = (col_ff == PosMax) ? PosMax : col_ff + PosOne;
         end
      end
      cnt_in = n;
   end

   // Lexer state and the result buffer; the payload loads with each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         star_ff <= 1'b0;
         row_ff  <= PosOne;
         col_ff  <= PosOne;
         cnt_ff  <= 2'd0;
         idx_ff  <= 2'd0;
      end else if (req_fire) begin
         mode_ff   <= mode_in;
         star_ff   <= star_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= 2'd0;
         kind_ff   <= kind_in;
         char_ff   <= char_in;
         line_ff   <= LineWidth'(row_ff);
         column_ff <= LineWidth'(col_ff);
      end else if (rsp_fire) begin
         if (last_beat) begin
            cnt_ff <= 2'd0;
            idx_ff <= 2'd0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   // The beat index always points inside the buffered results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < cnt_ff))
      else $error("result index beyond buffered count");

   // End of input restarts the stream at idle, row 1, column 1.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_char_in == CharEnd) |=>
         (mode_ff == MODE_IDLE && !star_ff && row_ff == PosOne && col_ff == PosOne))
      else $error("end of input did not restart the lexer");

   // End of input always gives at least one result beat.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_char_in == CharEnd) |=> rsp_valid)
      else $error("end of input gave no result");

   // With nothing buffered the input side is never held off.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty result buffer");

   // A taken beat that is not the last one moves on to the next slot.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !last_beat) |=> (rsp_valid && idx_ff == $past(idx_ff) + 2'd1))
      else $error("result buffer skipped or dropped a beat");

endmodule
